[rtl/micd_pkg.sv]
// Shared types and constants for the multi-input counter debouncer.
package micd_pkg;

    localparam int CNT_W         = 4;
    localparam int LEVEL_W       = 16;
    localparam int OUT_DATA_W    = 2 * LEVEL_W;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = CNT_W;
    localparam int NUM_INPUTS_DEF = 16;

    localparam logic [CFG_IDX_W-1:0] REG_COUNT_LIMIT       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_THRESHOLD   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE_THRESHOLD = 2'd2;

    localparam logic [CNT_W-1:0] COUNT_LIMIT_RST       = 4'd4;
    localparam logic [CNT_W-1:0] PRESS_THRESHOLD_RST   = 4'd4;
    localparam logic [CNT_W-1:0] RELEASE_THRESHOLD_RST = 4'd1;

    typedef struct packed {
        logic [CNT_W-1:0] count_limit;
        logic [CNT_W-1:0] press_threshold;
        logic [CNT_W-1:0] release_threshold;
    } micd_cfg_t;

    typedef struct packed {
        logic stable;
        logic press;
    } micd_lane_out_t;

endpackage

[rtl/micd_lane.sv]
// One debounce lane: saturating integrating counter and hysteresis bit.
module micd_lane
    import micd_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           step,
    input  logic           pressed,
    input  micd_cfg_t      cfg,
    output micd_lane_out_t lane_out
);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             stable_reg;
    logic             stable_next;

    always_comb
    begin
        count_next = count_reg;
        if (pressed)
        begin
            // A count above a lowered limit holds rather than snapping down.
            if (count_reg < cfg.count_limit)
            begin
                count_next = count_reg + CNT_W'(1);
            end
        end
        else if (count_reg != '0)
        begin
            count_next = count_reg - CNT_W'(1);
        end

        stable_next = stable_reg;
        if (count_next <= cfg.release_threshold)
        begin
            stable_next = 1'b0;
        end
        if (count_next >= cfg.press_threshold)
        begin
            stable_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            stable_reg <= 1'b0;
        end
        else if (step)
        begin
            count_reg  <= count_next;
            stable_reg <= stable_next;
        end
    end

    assign lane_out.stable = stable_next;
    assign lane_out.press  = stable_next & ~stable_reg;

endmodule

[rtl/micd_merge.sv]
// Gathers the lane results into one output word and holds it for the consumer.
module micd_merge
    import micd_pkg::*;
#(
    parameter int NUM_INPUTS = NUM_INPUTS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  micd_lane_out_t        lane_out [NUM_INPUTS],
    output logic                  ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [OUT_DATA_W-1:0] out_data
);

    // Number of lanes that have a place in the output fields.
    localparam int NUM_SHOWN = (NUM_INPUTS < LEVEL_W) ? NUM_INPUTS : LEVEL_W;

    logic [LEVEL_W-1:0] stable_w;
    logic [LEVEL_W-1:0] press_w;
    logic [LEVEL_W-1:0] stable_reg;
    logic [LEVEL_W-1:0] press_reg;
    logic               valid_reg;
    logic               valid_next;

    // Only the low inputs fit the output fields; the rest stay internal.
    always_comb
    begin
        stable_w = '0;
        press_w  = '0;
        for (int i = 0; i < NUM_SHOWN; i++)
        begin
            stable_w[i] = lane_out[i].stable;
            press_w[i]  = lane_out[i].press;
        end
    end

    assign ready = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            stable_reg <= stable_w;
            press_reg  <= press_w;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = {press_reg, stable_reg};

endmodule

[rtl/multi_input_counter_debouncer_core.sv]
// A tick's result is registered into the output stage at the edge that accepts the tick.
// Throughput: one tick per cycle; the output register takes a new result as it is
// consumed, so input ready drops only while a result waits and the consumer stalls.
// Every lane updates its counter in the cycle of acceptance.
// Reset (rst_n low, asynchronous): counters and debounced bits clear, output empties,
// count_limit = 4, press_threshold = 4, release_threshold = 1.
module multi_input_counter_debouncer_core
    import micd_pkg::*;
#(
    parameter int NUM_INPUTS = NUM_INPUTS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [LEVEL_W-1:0]    s_axis_tdata,   // [15:0] pin_levels
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [15:0] stable_levels, [31:16] press_events
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    micd_cfg_t      cfg_reg;
    micd_lane_out_t lane_out [NUM_INPUTS];
    logic           step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.count_limit       <= COUNT_LIMIT_RST;
            cfg_reg.press_threshold   <= PRESS_THRESHOLD_RST;
            cfg_reg.release_threshold <= RELEASE_THRESHOLD_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_COUNT_LIMIT:       cfg_reg.count_limit       <= cfg_wdata;
                REG_PRESS_THRESHOLD:   cfg_reg.press_threshold   <= cfg_wdata;
                REG_RELEASE_THRESHOLD: cfg_reg.release_threshold <= cfg_wdata;
                default:               ;
            endcase
        end
    end

    assign step = s_axis_tvalid && s_axis_tready;

    for (genvar i = 0; i < NUM_INPUTS; i++)
    begin : g_lane
        logic pressed;

        // Inputs past the level field have no pin and count as pressed.
        if (i < LEVEL_W)
        begin : g_pin
            assign pressed = ~s_axis_tdata[i];
        end
        else
        begin : g_nopin
            assign pressed = 1'b1;
        end

        micd_lane u_lane (
            .clk      (clk),
            .rst_n    (rst_n),
            .step     (step),
            .pressed  (pressed),
            .cfg      (cfg_reg),
            .lane_out (lane_out[i])
        );
    end

    micd_merge #(
        .NUM_INPUTS (NUM_INPUTS)
    ) u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (step),
        .lane_out  (lane_out),
        .ready     (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

endmodule

[rtl/micd_checker.sv]
// Port-level checks for the debouncer core, bound to the top level.
module micd_checker
    import micd_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata
);

    // A press event can only be reported for an input that is now pressed.
    a_press_implies_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |->
            ((m_axis_tdata[OUT_DATA_W-1:LEVEL_W] & ~m_axis_tdata[LEVEL_W-1:0]) == '0))
        else $error("press event on an input that is not pressed");

    // An empty output stage must never hold back the input.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled while output is empty");

    // Every accepted tick produces a result on the next cycle.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> m_axis_tvalid)
        else $error("accepted transaction produced no result");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled output transaction changed");

endmodule

bind multi_input_counter_debouncer_core micd_checker u_micd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

[tb/sv/tb_top.sv]
// Self-checking testbench for the multi-input counter debouncer core.
`timescale 1ns / 1ps

module tb_top;
    import micd_pkg::*;

    localparam int NUM_LANES = 16;
    localparam int STALL_LIMIT = 1000;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

    typedef struct packed {
        logic [LEVEL_W-1:0] stable_levels;
        logic [LEVEL_W-1:0] press_events;
    } debounce_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [LEVEL_W-1:0]    s_axis_tdata = '1;     // [15:0] pin_levels
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;          // [15:0] stable_levels, [31:16] press_events
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // Predicted state of the debouncer.
    logic [CNT_W-1:0]   lane_count [NUM_LANES];
    logic [LEVEL_W-1:0] stable_bits;
    logic [CNT_W-1:0]   limit_reg;
    logic [CNT_W-1:0]   press_reg;
    logic [CNT_W-1:0]   release_reg;

    debounce_result_t pending_results [$];

    int src_idle_pct = 0;
    int sink_stall_pct = 0;
    int mismatch_count = 0;
    int ticks_sent = 0;
    int results_seen = 0;
    int settings_applied = 0;
    int quiet_cycles = 0;

    multi_input_counter_debouncer_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    always #5 clk = ~clk;

    function void advance_debouncer(input logic [LEVEL_W-1:0] levels);
        logic [LEVEL_W-1:0] prior;
        logic [LEVEL_W-1:0] next_bits;
        logic [CNT_W-1:0]   cnt;
        debounce_result_t   res;
        prior = stable_bits;
        next_bits = stable_bits;
        for (int i = 0; i < NUM_LANES; i++)
        begin
            cnt = lane_count[i];
            // A low level means the button is held.
            if (!levels[i])
            begin
                if (cnt < limit_reg)
                    cnt = cnt + CNT_W'(1);
            end
            else if (cnt != '0)
                cnt = cnt - CNT_W'(1);
            lane_count[i] = cnt;
            if (cnt <= release_reg)
                next_bits[i] = 1'b0;
            if (cnt >= press_reg)
                next_bits[i] = 1'b1;
        end
        stable_bits = next_bits;
        res.stable_levels = next_bits;
        res.press_events = next_bits & ~prior;
        pending_results.push_back(res);
    endfunction

    // Called at a clock edge; returns at the edge where the transaction completes.
    task send_tick(input logic [LEVEL_W-1:0] levels);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= levels;
        do
            @(posedge clk);
        while (!s_axis_tready);
        advance_debouncer(levels);
        ticks_sent++;
    endtask

    // Always waits on the clock before it checks the queue, so back-to-back calls never drive twice at once.
    task wait_drained();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
    endtask

    task write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CNT_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        case (idx)
            REG_COUNT_LIMIT:       limit_reg = val;
            REG_PRESS_THRESHOLD:   press_reg = val;
            REG_RELEASE_THRESHOLD: release_reg = val;
            default: ;
        endcase
    endtask

    task apply_config(input logic [CNT_W-1:0] lim, input logic [CNT_W-1:0] prs,
                      input logic [CNT_W-1:0] rel);
        wait_drained();
        repeat (2) @(posedge clk);
        write_reg(REG_COUNT_LIMIT, lim);
        write_reg(REG_PRESS_THRESHOLD, prs);
        write_reg(REG_RELEASE_THRESHOLD, rel);
        cfg_we <= 1'b0;
        settings_applied++;
    endtask

    // Reset thresholds: a held button needs four ticks to register, then release.
    task test_reset_defaults();
        repeat (6) send_tick(16'h0000);
        repeat (5) send_tick(16'hFFFF);
        repeat (2) send_tick(16'hAAAA);
        repeat (2) send_tick(16'h5555);
    endtask

    // Lower the count limit under charged counters, then a zero limit.
    task test_limit_changes();
        apply_config(4'd6, 4'd3, 4'd1);
        repeat (6) send_tick(16'h0F0F);
        apply_config(4'd2, 4'd2, 4'd0);
        repeat (2) send_tick(16'hFF00);
        apply_config(4'd0, 4'd0, 4'd0);
        repeat (2) send_tick(16'h0000);
    endtask

    // A write to the unused index must leave every register alone.
    task test_unmapped_register();
        wait_drained();
        repeat (2) @(posedge clk);
        write_reg(REG_UNMAPPED, 4'hF);
        cfg_we <= 1'b0;
        send_tick(16'h0000);
        send_tick(16'hFFFF);
    endtask

    // Buttons that mostly hold their level, with contact bounce and some pure noise.
    task test_random_pacing(input int n_ticks, input int src_pct, input int sink_pct,
                            input logic [CNT_W-1:0] lim, input logic [CNT_W-1:0] prs,
                            input logic [CNT_W-1:0] rel);
        logic [LEVEL_W-1:0] held;
        logic [LEVEL_W-1:0] bounce;
        int roll;
        apply_config(lim, prs, rel);
        src_idle_pct = src_pct;
        sink_stall_pct = sink_pct;
        held = LEVEL_W'($urandom);
        for (int k = 0; k < n_ticks; k++)
        begin
            if (k == n_ticks / 2)
                wait_drained();
            roll = $urandom_range(99);
            if (roll < 6)
                held[$urandom_range(NUM_LANES - 1)] ^= 1'b1;
            bounce = '0;
            if (roll < 10)
                bounce = LEVEL_W'($urandom);
            else if (roll < 40)
                bounce = LEVEL_W'($urandom & $urandom & $urandom);
            send_tick(held ^ bounce);
        end
        wait_drained();
        src_idle_pct = 0;
        sink_stall_pct = 0;
    endtask

    always @(posedge clk)
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                $error("result 0x%08h arrived with no tick outstanding", m_axis_tdata);
                mismatch_count++;
            end
            else
            begin
                debounce_result_t want;
                want = pending_results.pop_front();
                if (m_axis_tdata[LEVEL_W-1:0] !== want.stable_levels)
                begin
                    $error("stable_levels: expected 0x%04h, got 0x%04h",
                           want.stable_levels, m_axis_tdata[LEVEL_W-1:0]);
                    mismatch_count++;
                end
                if (m_axis_tdata[OUT_DATA_W-1:LEVEL_W] !== want.press_events)
                begin
                    $error("press_events: expected 0x%04h, got 0x%04h",
                           want.press_events, m_axis_tdata[OUT_DATA_W-1:LEVEL_W]);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        for (int i = 0; i < NUM_LANES; i++)
            lane_count[i] = '0;
        stable_bits = '0;
        limit_reg = COUNT_LIMIT_RST;
        press_reg = PRESS_THRESHOLD_RST;
        release_reg = RELEASE_THRESHOLD_RST;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_limit_changes();
        test_unmapped_register();

        test_random_pacing(250, 0, 0, COUNT_LIMIT_RST, PRESS_THRESHOLD_RST,
                           RELEASE_THRESHOLD_RST);
        test_random_pacing(250, 59, 0, 4'd15, 4'd15, 4'd0);
        test_random_pacing(250, 0, 59, 4'd1, 4'd1, 4'd0);
        test_random_pacing(250, 26, 26, 4'd15, 4'd0, 4'd15);
        test_random_pacing(250, 0, 0, CNT_W'($urandom), CNT_W'($urandom),
                           CNT_W'($urandom));
        test_random_pacing(250, 59, 0, CNT_W'($urandom), CNT_W'($urandom),
                           CNT_W'($urandom));
        test_random_pacing(250, 0, 59, CNT_W'($urandom), CNT_W'($urandom),
                           CNT_W'($urandom));
        test_random_pacing(250, 26, 26, CNT_W'($urandom_range(15, 8)),
                           CNT_W'($urandom_range(7)), CNT_W'($urandom_range(3)));

        wait_drained();
        repeat (5) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            $error("%0d expected results never arrived", pending_results.size());
            mismatch_count++;
        end

        $display("Sent %0d sampling ticks and checked %0d results under %0d register settings,",
                 ticks_sent, results_seen, settings_applied);
        $display("with free-running, sender-gapped, receiver-stalled and mixed pacing.");
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

[sim.f]
rtl/micd_pkg.sv
rtl/micd_lane.sv
rtl/micd_merge.sv
rtl/multi_input_counter_debouncer_core.sv
rtl/micd_checker.sv
tb/sv/tb_top.sv
